// ===== rtl/cursor_linked_list_engine_top_assert.svh =====
// Assertion helpers for the linked list engine. They expect clock and reset in scope.
`ifndef CURSOR_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// Check that a condition holds at every edge outside reset.
`define CLL_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CLL_CHECK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cll_pkg.sv =====
package cll_pkg;

   localparam int DEPTH_DEF      = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W  = 4;
   localparam int ITEM_W = 32;
   localparam int POS_W  = 9;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND = 4'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd3;
   localparam logic [CMD_W-1:0] CMD_START  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_END    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_PREV   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_MOVE   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_GET    = 4'd9;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 4'd10;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ITEM_W-1:0] item_value;
      logic [POS_W-1:0]  target_position;
   } req_type;

   typedef struct packed {
      logic [ITEM_W-1:0] read_value;
      logic [POS_W-1:0]  list_length;
      logic [POS_W-1:0]  cursor_position;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC,
      S_LINK1,
      S_LINK2,
      S_RD_AFTER,
      S_RD2,
      S_FREE,
      S_WALK,
      S_FINISH
   } state_type;

   typedef struct packed {
      state_type step;
      logic      accept;
      logic      load_rsp;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             cur_zero;
      logic             cur_tail;
      logic             pos_over;
      logic             pos_zero;
      logic             after_zero;
      logic             walk_done;
      logic             out_free;
   } stat_type;

endpackage

// ===== rtl/cll_ctrl.sv =====
`include "cursor_linked_list_engine_top_assert.svh"

module cll_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cll_pkg::stat_type  stat,
   output cll_pkg::ctl_type   ctl
);

   cll_pkg::state_type state_ff;
   cll_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cll_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl.step     = state_ff;
      ctl.accept   = 1'b0;
      ctl.load_rsp = 1'b0;
      req_stall    = (state_ff != cll_pkg::S_IDLE);
      unique case (state_ff)
         cll_pkg::S_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = cll_pkg::S_DECODE;
            end
         end
         cll_pkg::S_DECODE: begin
            unique case (stat.cmd)
               cll_pkg::CMD_INSERT, cll_pkg::CMD_APPEND: begin
                  state_in = stat.full ? cll_pkg::S_FINISH : cll_pkg::S_ALLOC;
               end
               cll_pkg::CMD_REMOVE, cll_pkg::CMD_GET: begin
                  state_in = cll_pkg::S_RD_AFTER;
               end
               cll_pkg::CMD_NEXT: begin
                  state_in = stat.cur_tail ? cll_pkg::S_FINISH : cll_pkg::S_RD_AFTER;
               end
               cll_pkg::CMD_PREV: begin
                  state_in = stat.cur_zero ? cll_pkg::S_FINISH : cll_pkg::S_WALK;
               end
               cll_pkg::CMD_MOVE: begin
                  state_in = (stat.pos_over || stat.pos_zero) ? cll_pkg::S_FINISH
                                                              : cll_pkg::S_WALK;
               end
               default: begin
                  state_in = cll_pkg::S_FINISH;
               end
            endcase
         end
         cll_pkg::S_ALLOC:  state_in = cll_pkg::S_LINK1;
         cll_pkg::S_LINK1:  state_in = cll_pkg::S_LINK2;
         cll_pkg::S_LINK2:  state_in = cll_pkg::S_FINISH;
         cll_pkg::S_RD_AFTER: begin
            if (stat.cmd == cll_pkg::CMD_NEXT || stat.after_zero) begin
               state_in = cll_pkg::S_FINISH;
            end else begin
               state_in = cll_pkg::S_RD2;
            end
         end
         cll_pkg::S_RD2: begin
            state_in = (stat.cmd == cll_pkg::CMD_REMOVE) ? cll_pkg::S_FREE
                                                         : cll_pkg::S_FINISH;
         end
         cll_pkg::S_FREE:   state_in = cll_pkg::S_FINISH;
         cll_pkg::S_WALK: begin
            if (stat.walk_done) begin
               state_in = cll_pkg::S_FINISH;
            end
         end
         cll_pkg::S_FINISH: begin
            if (stat.out_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = cll_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cll_pkg::S_IDLE;
         end
      endcase
   end

   `CLL_CHECK_NEXT(a_accept_decode, ctl.accept, state_ff == cll_pkg::S_DECODE,
      "accepted request did not reach decode")
   `CLL_CHECK_NEXT(a_load_idle, ctl.load_rsp, state_ff == cll_pkg::S_IDLE,
      "controller busy after response load")

endmodule

// ===== rtl/cll_dp.sv =====
`include "cursor_linked_list_engine_top_assert.svh"

module cll_dp #(
   parameter int DEPTH      = cll_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cll_pkg::ctl_type  ctl,
   output cll_pkg::stat_type stat,
   input  cll_pkg::req_type  req_data,
   output cll_pkg::rsp_type  rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall
);

   localparam int NW   = $clog2(DEPTH + 1);
   localparam int CMPW = (NW > cll_pkg::POS_W) ? NW : cll_pkg::POS_W;
   localparam logic [NW-1:0] NODE_NULL = '0;
   localparam logic [NW-1:0] DEPTH_N   = NW'(DEPTH);

   // node slots 1..DEPTH; the sentinel link lives in a register
   logic [NW-1:0]         link_mem [1:DEPTH];
   logic [DATA_WIDTH-1:0] elem_mem [1:DEPTH];

   logic [cll_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [cll_pkg::ITEM_W-1:0] val_ff, val_in;
   logic [cll_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [NW-1:0] free_head_ff, free_head_in;
   logic [NW-1:0] fresh_ff, fresh_in;
   logic [NW-1:0] tail_ff, tail_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] sent_link_ff, sent_link_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW-1:0] t_ff, t_in;
   logic [NW-1:0] walk_ff, walk_in;
   logic [cll_pkg::ITEM_W-1:0] rv_ff, rv_in;
   logic [cll_pkg::STAT_W-1:0] st_ff, st_in;
   cll_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0]         link_q_ff;
   logic                  sent_sel_ff;
   logic [DATA_WIDTH-1:0] elem_q_ff;

   logic                  link_re, link_we, elem_re, elem_we;
   logic [NW-1:0]         link_raddr, link_waddr, link_wdata, elem_raddr;
   logic [NW-1:0]         link_dat, new_node;
   logic [DATA_WIDTH-1:0] elem_wdata;
   logic [63:0]           val64, rd64;
   logic [CMPW-1:0]       pos_ext, cnt_ext, idx_ext, walk_next;

   assign link_dat  = sent_sel_ff ? sent_link_ff : link_q_ff;
   assign val64     = 64'(val_ff);
   assign elem_wdata = val64[DATA_WIDTH-1:0];
   assign rd64      = 64'(elem_q_ff);
   assign pos_ext   = CMPW'(pos_ff);
   assign cnt_ext   = CMPW'(count_ff);
   assign idx_ext   = CMPW'(idx_ff);
   assign walk_next = CMPW'(walk_ff) + CMPW'(1);
   assign new_node  = (free_head_ff == NODE_NULL) ? (fresh_ff + NW'(1)) : free_head_ff;

   assign stat.cmd        = cmd_ff;
   assign stat.full       = (count_ff >= DEPTH_N);
   assign stat.cur_zero   = (cur_ff == NODE_NULL);
   assign stat.cur_tail   = (cur_ff == tail_ff);
   assign stat.pos_over   = (pos_ext > cnt_ext);
   assign stat.pos_zero   = (pos_ff == '0);
   assign stat.after_zero = (link_dat == NODE_NULL);
   assign stat.walk_done  = (cmd_ff == cll_pkg::CMD_PREV)
                            ? ((link_dat == cur_ff) || (walk_ff == DEPTH_N))
                            : (walk_next == pos_ext);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (link_we && link_waddr != NODE_NULL) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_q_ff   <= link_mem[link_raddr];
         sent_sel_ff <= (link_raddr == NODE_NULL);
      end
      if (elem_we) begin
         elem_mem[new_node] <= elem_wdata;
      end
      if (elem_re) begin
         elem_q_ff <= elem_mem[elem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fresh_ff     <= '0;
         tail_ff      <= '0;
         cur_ff       <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         sent_link_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         sent_link_ff <= sent_link_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      pos_ff  <= pos_in;
      node_ff <= node_in;
      t_ff    <= t_in;
      walk_ff <= walk_in;
      rv_ff   <= rv_in;
      st_ff   <= st_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      sent_link_in = sent_link_ff;
      node_in      = node_ff;
      t_in         = t_ff;
      walk_in      = walk_ff;
      rv_in        = rv_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      link_re      = 1'b0;
      link_raddr   = cur_ff;
      link_we      = 1'b0;
      link_waddr   = node_ff;
      link_wdata   = NODE_NULL;
      elem_re      = 1'b0;
      elem_raddr   = node_ff;
      elem_we      = 1'b0;

      if (ctl.accept) begin
         cmd_in = req_data.command;
         val_in = req_data.item_value;
         pos_in = req_data.target_position;
      end

      unique case (ctl.step)
         cll_pkg::S_DECODE: begin
            rv_in = '0;
            st_in = cll_pkg::ST_OK;
            unique case (cmd_ff)
               cll_pkg::CMD_CLEAR: begin
                  free_head_in = '0;
                  fresh_in     = '0;
                  tail_in      = '0;
                  cur_in       = '0;
                  idx_in       = '0;
                  count_in     = '0;
                  sent_link_in = '0;
               end
               cll_pkg::CMD_INSERT, cll_pkg::CMD_APPEND: begin
                  if (stat.full) begin
                     st_in = cll_pkg::ST_FULL;
                  end else begin
                     // fetch the successor of the first freed slot
                     link_re    = 1'b1;
                     link_raddr = free_head_ff;
                  end
               end
               cll_pkg::CMD_REMOVE, cll_pkg::CMD_GET, cll_pkg::CMD_NEXT: begin
                  link_re    = 1'b1;
                  link_raddr = cur_ff;
               end
               cll_pkg::CMD_START: begin
                  cur_in = '0;
                  idx_in = '0;
               end
               cll_pkg::CMD_END: begin
                  cur_in = tail_ff;
                  idx_in = count_ff;
               end
               cll_pkg::CMD_PREV: begin
                  t_in       = '0;
                  walk_in    = '0;
                  link_re    = 1'b1;
                  link_raddr = NODE_NULL;
               end
               cll_pkg::CMD_MOVE: begin
                  if (stat.pos_over) begin
                     st_in = cll_pkg::ST_RANGE;
                  end else if (stat.pos_zero) begin
                     cur_in = '0;
                     idx_in = '0;
                  end else begin
                     t_in       = '0;
                     walk_in    = '0;
                     link_re    = 1'b1;
                     link_raddr = NODE_NULL;
                  end
               end
               default: ;
            endcase
         end
         cll_pkg::S_ALLOC: begin
            if (free_head_ff != NODE_NULL) begin
               free_head_in = link_dat;
            end else begin
               fresh_in = fresh_ff + NW'(1);
            end
            elem_we    = 1'b1;
            node_in    = new_node;
            link_re    = 1'b1;
            link_raddr = cur_ff;
         end
         cll_pkg::S_LINK1: begin
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = (cmd_ff == cll_pkg::CMD_INSERT) ? link_dat : NODE_NULL;
         end
         cll_pkg::S_LINK2: begin
            link_we    = 1'b1;
            link_wdata = node_ff;
            if (cmd_ff == cll_pkg::CMD_INSERT) begin
               link_waddr = cur_ff;
               if (tail_ff == cur_ff) begin
                  tail_in = node_ff;
               end
            end else begin
               link_waddr = tail_ff;
               tail_in    = node_ff;
            end
            count_in = count_ff + NW'(1);
         end
         cll_pkg::S_RD_AFTER: begin
            if (cmd_ff == cll_pkg::CMD_NEXT) begin
               cur_in = link_dat;
               idx_in = idx_ff + NW'(1);
            end else if (link_dat == NODE_NULL) begin
               st_in = cll_pkg::ST_EMPTY;
            end else begin
               node_in    = link_dat;
               elem_re    = 1'b1;
               elem_raddr = link_dat;
               link_re    = 1'b1;
               link_raddr = link_dat;
            end
         end
         cll_pkg::S_RD2: begin
            rv_in = rd64[cll_pkg::ITEM_W-1:0];
            if (cmd_ff == cll_pkg::CMD_REMOVE) begin
               if (tail_ff == node_ff) begin
                  tail_in = cur_ff;
               end
               link_we    = 1'b1;
               link_waddr = cur_ff;
               link_wdata = link_dat;
               if (count_ff != '0) begin
                  count_in = count_ff - NW'(1);
               end
            end
         end
         cll_pkg::S_FREE: begin
            link_we      = 1'b1;
            link_waddr   = node_ff;
            link_wdata   = free_head_ff;
            free_head_in = node_ff;
         end
         cll_pkg::S_WALK: begin
            if (stat.walk_done) begin
               if (cmd_ff == cll_pkg::CMD_PREV) begin
                  cur_in = t_ff;
                  if (idx_ff != '0) begin
                     idx_in = idx_ff - NW'(1);
                  end
               end else begin
                  cur_in = link_dat;
                  idx_in = pos_ext[NW-1:0];
               end
            end else begin
               // advance one link and fetch the next
               t_in       = link_dat;
               walk_in    = walk_ff + NW'(1);
               link_re    = 1'b1;
               link_raddr = link_dat;
            end
         end
         default: ;
      endcase

      if (link_we && link_waddr == NODE_NULL) begin
         sent_link_in = link_wdata;
      end

      if (ctl.load_rsp) begin
         rsp_in.read_value      = rv_ff;
         rsp_in.list_length     = cnt_ext[cll_pkg::POS_W-1:0];
         rsp_in.cursor_position = idx_ext[cll_pkg::POS_W-1:0];
         rsp_in.status          = st_ff;
      end
      rsp_valid_in = ctl.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   `CLL_CHECK(a_count_bound, count_ff <= DEPTH_N, "list length beyond depth")
   `CLL_CHECK(a_cursor_bound, idx_ff <= count_ff, "cursor past end of list")
   `CLL_CHECK(a_cursor_head, (idx_ff == '0) == (cur_ff == NODE_NULL),
      "cursor node and position disagree on head")

endmodule

// ===== rtl/cursor_linked_list_engine_top.sv =====
// Singly linked list engine with a cursor, up to DEPTH elements.
// Request channel (req_valid, req_stall, req_data): one command with its
// element and target position; a request is taken when req_valid is high and
// req_stall is low. req_stall stays high while a command is being worked on.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response per
// request, in order, carrying the value, length, cursor position and status.
// Step back and move to position walk the links from the head, one link
// per cycle through the link memory read port. One command is processed
// at a time.
// The response register holds its result while rsp_stall is high; the next
// request may be taken meanwhile, and its result waits until the register
// frees up.
// Reset (synchronous, active high) empties the list and parks the cursor on
// the head; no clearing pass is needed, and requests are taken right after.
module cursor_linked_list_engine_top #(
   parameter int DEPTH      = cll_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cll_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cll_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cll_pkg::rsp_type rsp_data
);

   cll_pkg::ctl_type  ctl;
   cll_pkg::stat_type stat;

   // sequence each command through its memory steps
   cll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // hold list pointers, node memories and the response register
   cll_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule
